// ----- rtl/core/aflt_pkg.sv -----
// shared types and constants of the advisory file lock table
package aflt_pkg;

  localparam int unsigned DefTableDepth = 32;
  localparam logic [30:0] EndOfFile = 31'h7FFF_FFFF;

  localparam logic [2:0] ReqWholeLock   = 3'd0;
  localparam logic [2:0] ReqWholeUnlock = 3'd1;
  localparam logic [2:0] ReqQuery       = 3'd2;
  localparam logic [2:0] ReqRangeSet    = 3'd3;
  localparam logic [2:0] ReqRelease     = 3'd4;

  localparam logic [1:0] KindRead  = 2'd0;
  localparam logic [1:0] KindWrite = 2'd1;
  localparam logic [1:0] KindNone  = 2'd2;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusConflict = 2'd1;
  localparam logic [1:0] StatusFull     = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StUpdate,
    StLen,
    StDone
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_step;
    logic apply;
    logic calc_len;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic need_len;
  } dp_stat_t;

endpackage

// ----- rtl/core/aflt_datapath.sv -----
// entry store, request registers, scan matches and result registers
module aflt_datapath import aflt_pkg::*; #(
  parameter int unsigned TableDepth = DefTableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  input  logic [2:0]  req_type_i,
  input  logic [15:0] file_id_i,
  input  logic [15:0] owner_pid_i,
  input  logic [1:0]  lock_kind_i,
  input  logic [30:0] range_start_i,
  input  logic [30:0] range_len_i,
  output logic [1:0]  status_o,
  output logic [1:0]  conflict_kind_o,
  output logic [30:0] conflict_start_o,
  output logic [30:0] conflict_len_o,
  output logic [15:0] conflict_pid_o
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableDepth - 1);

  logic [TableDepth-1:0] valid_q;
  logic [15:0] file_q  [TableDepth];
  logic [15:0] owner_q [TableDepth];
  logic        wr_q    [TableDepth];
  logic [30:0] first_q [TableDepth];
  logic [30:0] last_q  [TableDepth];
  logic        whole_q [TableDepth];

  logic [2:0]  req_q;
  logic [15:0] rfile_q, rowner_q;
  logic [1:0]  rkind_q;
  logic [30:0] rstart_q, rlast_q;
  logic [31:0] sum_w;

  logic [IdxW-1:0] idx_q;
  logic conf_hit_q, match_hit_q, free_hit_q;
  logic [IdxW-1:0] conf_idx_q, match_idx_q, free_idx_q;
  logic [TableDepth-1:0] clr_q;

  logic [1:0]  status_q, ckind_q;
  logic [30:0] cstart_q, clen_q, clast_q;
  logic [15:0] cpid_q;
  logic        strobe_q;

  logic [30:0] q_first, q_last, e_first, e_last;
  logic        e_valid, e_same, e_other, e_conf, e_read, overlap;
  logic        whole_req, set_unlock;

  assign sum_w = {1'b0, range_start_i} + {1'b0, range_len_i} - 32'd1;

  always_comb begin
    whole_req = (req_q == ReqWholeLock);
    set_unlock = (req_q == ReqRangeSet) && rkind_q[1];
    e_read = whole_req ? (rkind_q != KindWrite) : (rkind_q == KindRead);
    q_first = whole_req ? 31'd0 : rstart_q;
    q_last = whole_req ? EndOfFile : rlast_q;
    e_valid = valid_q[idx_q] && (file_q[idx_q] == rfile_q);
    e_same = e_valid && (owner_q[idx_q] == rowner_q);
    e_other = e_valid && (owner_q[idx_q] != rowner_q);
    e_first = first_q[idx_q];
    e_last = last_q[idx_q];
    overlap = !(q_first > e_last || q_last < e_first);
    e_conf = e_other && !(!wr_q[idx_q] && e_read) && (whole_q[idx_q] || overlap);
  end

  assign stat_o.scan_last = (idx_q == LastIdx);
  assign stat_o.need_len = (req_q == ReqQuery) && conf_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      strobe_q <= 1'b0;
      req_q <= '0;
      idx_q <= '0;
      conf_hit_q <= 1'b0;
      match_hit_q <= 1'b0;
      free_hit_q <= 1'b0;
      clr_q <= '0;
    end else begin
      strobe_q <= cmd_i.emit;
      if (cmd_i.load) begin
        req_q <= req_type_i;
        rfile_q <= file_id_i;
        rowner_q <= owner_pid_i;
        rkind_q <= lock_kind_i;
        rstart_q <= range_start_i;
        if (range_len_i == '0 || sum_w > {1'b0, EndOfFile}) rlast_q <= EndOfFile;
        else rlast_q <= sum_w[30:0];
      end
      if (cmd_i.scan_clr) begin
        idx_q <= '0;
        conf_hit_q <= 1'b0;
        match_hit_q <= 1'b0;
        free_hit_q <= 1'b0;
        clr_q <= '0;
      end else if (cmd_i.scan_step) begin
        if (!stat_o.scan_last) idx_q <= idx_q + 1'b1;
        if (e_conf && !conf_hit_q) begin
          conf_hit_q <= 1'b1;
          conf_idx_q <= idx_q;
        end
        if (!valid_q[idx_q] && !free_hit_q) begin
          free_hit_q <= 1'b1;
          free_idx_q <= idx_q;
        end
        if (!match_hit_q && e_same && whole_q[idx_q] == (req_q != ReqRangeSet) &&
            (req_q != ReqRangeSet || (e_first == rstart_q && e_last == rlast_q))) begin
          match_hit_q <= 1'b1;
          match_idx_q <= idx_q;
        end
        if ((req_q == ReqRelease && e_same) ||
            (set_unlock && e_same && !whole_q[idx_q] &&
             e_first <= rlast_q && e_last >= rstart_q))
          clr_q[idx_q] <= 1'b1;
      end
      if (cmd_i.apply) begin
        case (req_q)
          ReqWholeLock, ReqRangeSet: begin
            if (set_unlock) valid_q <= valid_q & ~clr_q;
            else if (!conf_hit_q) begin
              if (match_hit_q) wr_q[match_idx_q] <= (rkind_q == KindWrite);
              else if (free_hit_q) begin
                valid_q[free_idx_q] <= 1'b1;
                file_q[free_idx_q] <= rfile_q;
                owner_q[free_idx_q] <= rowner_q;
                wr_q[free_idx_q] <= (rkind_q == KindWrite);
                first_q[free_idx_q] <= q_first;
                last_q[free_idx_q] <= q_last;
                whole_q[free_idx_q] <= whole_req;
              end
            end
          end
          ReqWholeUnlock: if (match_hit_q) valid_q[match_idx_q] <= 1'b0;
          ReqRelease: valid_q <= valid_q & ~clr_q;
          default: ;
        endcase
        status_q <= StatusOk;
        ckind_q <= KindNone;
        cstart_q <= '0;
        clen_q <= '0;
        cpid_q <= '0;
        if ((req_q == ReqWholeLock || (req_q == ReqRangeSet && !set_unlock))) begin
          if (conf_hit_q) status_q <= StatusConflict;
          else if (!match_hit_q && !free_hit_q) status_q <= StatusFull;
        end
        if (req_q == ReqQuery && conf_hit_q) begin
          ckind_q <= wr_q[conf_idx_q] ? KindWrite : KindRead;
          cstart_q <= first_q[conf_idx_q];
          clast_q <= last_q[conf_idx_q];
          cpid_q <= owner_q[conf_idx_q];
        end
      end
      if (cmd_i.calc_len)
        clen_q <= (clast_q == EndOfFile) ? 31'd0 : (clast_q - cstart_q + 31'd1);
    end
  end

  assign status_o = strobe_q ? status_q : StatusOk;
  assign conflict_kind_o = ckind_q;
  assign conflict_start_o = cstart_q;
  assign conflict_len_o = clen_q;
  assign conflict_pid_o = cpid_q;

  // a match found for update must be of this owner
  a_match_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply && match_hit_q && valid_q[match_idx_q] |->
      owner_q[match_idx_q] == rowner_q) else $error("match owner mismatch");
  // a conflict entry never belongs to the requester
  a_conf_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply && conf_hit_q |-> owner_q[conf_idx_q] != rowner_q)
    else $error("conflict with own entry");
  // scan wraps only through clear
  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step && !stat_o.scan_last |=> idx_q == $past(idx_q) + 1'b1)
    else $error("scan index slip");

endmodule

// ----- rtl/core/aflt_ctrl.sv -----
// controller state machine of the advisory file lock table
module aflt_ctrl import aflt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  output logic     done_o,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    busy_o = (state_q != StIdle);
    done_o = 1'b0;
    case (state_q)
      StIdle: if (start_i) begin
        cmd_o.load = 1'b1;
        cmd_o.scan_clr = 1'b1;
        state_d = StScan;
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = StUpdate;
      end
      StUpdate: begin
        cmd_o.apply = 1'b1;
        state_d = stat_i.need_len ? StLen : StDone;
        if (!stat_i.need_len) cmd_o.emit = 1'b1;
      end
      StLen: begin
        cmd_o.calc_len = 1'b1;
        cmd_o.emit = 1'b1;
        state_d = StDone;
      end
      StDone: begin
        done_o = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  a_emit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> !cmd_o.emit) else $error("double result");
  a_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !cmd_o.load) else $error("load while busy");
  a_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cmd_o.emit)) else $error("done without result");

endmodule

// ----- rtl/core/advisory_file_lock_table.sv -----
// top level of the advisory file lock table
// channel  | ports                              | handshake
// request  | req_type_i .. range_len_i          | start_i high while busy_o low
// result   | status_o .. conflict_pid_o         | done_o high for one cycle
// the result word comes with done_o after a sequential scan over the table, one entry
// per cycle, then update, a length step only for a query that finds a conflict, and
// result; busy_o falls in the cycle after done_o
// reset clears every valid bit at once; no clearing pass
// results cannot be stalled
module advisory_file_lock_table import aflt_pkg::*; #(
  parameter int unsigned TableDepth = DefTableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  output logic        done_o,
  input  logic [2:0]  req_type_i,
  input  logic [15:0] file_id_i,
  input  logic [15:0] owner_pid_i,
  input  logic [1:0]  lock_kind_i,
  input  logic [30:0] range_start_i,
  input  logic [30:0] range_len_i,
  output logic [1:0]  status_o,
  output logic [1:0]  conflict_kind_o,
  output logic [30:0] conflict_start_o,
  output logic [30:0] conflict_len_o,
  output logic [15:0] conflict_pid_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  aflt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o, .done_o,
    .cmd_o(cmd), .stat_i(stat)
  );

  aflt_datapath #(.TableDepth(TableDepth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .req_type_i, .file_id_i, .owner_pid_i, .lock_kind_i, .range_start_i,
    .range_len_i, .status_o, .conflict_kind_o, .conflict_start_o,
    .conflict_len_o, .conflict_pid_o
  );

endmodule
